[hdl/sra_pkg.sv]
`default_nettype none
package sra_pkg;
  localparam int REG_COUNT = 16;
  localparam int IDX_W = $clog2(REG_COUNT);

  localparam logic [2:0] OP_SET  = 3'd0;
  localparam logic [2:0] OP_COPY = 3'd1;
  localparam logic [2:0] OP_ALU  = 3'd2;
  localparam logic [2:0] OP_CMP  = 3'd3;
  localparam logic [2:0] OP_JUMP = 3'd4;
  localparam logic [2:0] OP_SHOW = 3'd5;

  localparam logic [3:0] F_ADD = 4'd0;
  localparam logic [3:0] F_SUB = 4'd1;
  localparam logic [3:0] F_MUL = 4'd2;
  localparam logic [3:0] F_DIV = 4'd3;
  localparam logic [3:0] F_MOD = 4'd4;
  localparam logic [3:0] F_POW = 4'd5;
  localparam logic [3:0] F_AND = 4'd6;
  localparam logic [3:0] F_OR  = 4'd7;
  localparam logic [3:0] F_XOR = 4'd8;
  localparam logic [3:0] F_SHL = 4'd9;
  localparam logic [3:0] F_SHR = 4'd10;

  localparam logic [3:0] C_EQ = 4'd0;
  localparam logic [3:0] C_NE = 4'd1;
  localparam logic [3:0] C_GT = 4'd2;
  localparam logic [3:0] C_LT = 4'd3;
  localparam logic [3:0] C_GE = 4'd4;
  localparam logic [3:0] C_LE = 4'd5;

  localparam logic [3:0] J_REL = 4'd0;

  // wrap a signed index modulo the register count
  function automatic logic [IDX_W-1:0] wrap_idx(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v % REG_COUNT;
    if (r < 0) r = r + REG_COUNT;
    return r[IDX_W-1:0];
  endfunction
endpackage
`default_nettype wire

[hdl/script_register_alu_unit.sv]
// the result beat follows the states RDB, RDA, EXE, then DIV or POW for div/mod/pow, and FIN
// one command at a time: in_tready returns the cycle after the result beat is accepted,
// so a new command waits for the last result; the divider and pow loop run longest
// register file is a 16-entry synchronous memory, one read port used in RDB and then in RDA
// reset: rst_n synchronous active low; clears control and line counter, then sweeps
// the register file to zero while in_tready stays low
`default_nettype none
module script_register_alu_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // op[2:0], target_index[18:3], source_index[34:19], func[38:35], operand[70:39],
  // operand_is_register[71], skip_offset[103:72], interactive[104], zero fill
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // line_number[31:0], register_value[63:32], wrote[64], divide_by_zero[65], zero fill
  output logic [71:0]       out_tdata
);
  localparam int IW = sra_pkg::IDX_W;

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_RDB  = 8'b00000100,
    S_RDA  = 8'b00001000,
    S_EXE  = 8'b00010000,
    S_DIV  = 8'b00100000,
    S_POW  = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] mem [sra_pkg::REG_COUNT];
  logic [IW-1:0] raddr;
  logic [31:0] rdata_r;
  logic        we;
  logic [IW-1:0] waddr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic [2:0]  op_r;
  logic [IW-1:0] tgt_r, src_r, oidx_r;
  logic [3:0]  func_r;
  logic [31:0] opnd_r, skip_r, b_r, line_r;
  logic        oreg_r, cli_r;
  logic [IW-1:0] clr_r;

  logic [31:0] res_r, res_nxt;
  logic        wrote_r, wrote_nxt, dz_r, dz_nxt;

  // divider / pow working regs
  logic [31:0] q_r, rem_r, dvs_r, base_r, exp_r, acc_r;
  logic [5:0]  cnt_r;
  logic        qneg_r, rneg_r;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] mul_ab, pow_m1, pow_m2;

  logic [31:0] ua, ub;
  logic signed [31:0] sa, sb;
  logic cmp;

  assign in_tready = (state_r == S_IDLE);
  assign out_tdata = {6'b0, dz_r, wrote_r, res_r, line_r};

  // in EXE rdata_r holds the target (or copy source) register
  assign sa = rdata_r;
  assign sb = b_r;
  assign ua = sa[31] ? -rdata_r : rdata_r;
  assign ub = sb[31] ? -b_r : b_r;
  assign mul_ab = rdata_r * b_r;
  assign pow_m1 = acc_r * base_r;
  assign pow_m2 = base_r * base_r;
  assign rem_sh = {rem_r[30:0], q_r[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_comb begin
    unique case (state_r)
      S_RDB:   raddr = oidx_r;
      S_RDA:   raddr = (op_r == sra_pkg::OP_COPY) ? src_r : tgt_r;
      default: raddr = tgt_r;
    endcase
  end

  always_comb begin
    case (func_r)
      sra_pkg::C_EQ: cmp = sa == sb;
      sra_pkg::C_NE: cmp = sa != sb;
      sra_pkg::C_GT: cmp = sa > sb;
      sra_pkg::C_LT: cmp = sa < sb;
      sra_pkg::C_GE: cmp = sa >= sb;
      sra_pkg::C_LE: cmp = sa <= sb;
      default:       cmp = 1'b0;
    endcase
  end

  assign we    = (state_r == S_CLR) || (state_r == S_FIN && wrote_r && !out_tvalid);
  assign waddr = (state_r == S_CLR) ? clr_r : tgt_r;
  assign wdata = (state_r == S_CLR) ? 32'd0 : res_r;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    wrote_nxt = wrote_r;
    dz_nxt    = dz_r;
    unique case (state_r)
      S_CLR:  if (clr_r == IW'(sra_pkg::REG_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) state_nxt = S_RDB;
      S_RDB:  state_nxt = S_RDA;
      S_RDA:  state_nxt = S_EXE;
      S_EXE: begin
        res_nxt = 32'd0; wrote_nxt = 1'b0; dz_nxt = 1'b0;
        state_nxt = S_FIN;
        case (op_r)
          sra_pkg::OP_SET:  begin res_nxt = opnd_r; wrote_nxt = 1'b1; end
          sra_pkg::OP_COPY: begin res_nxt = rdata_r; wrote_nxt = 1'b1; end
          sra_pkg::OP_SHOW: res_nxt = rdata_r;
          sra_pkg::OP_ALU: begin
            wrote_nxt = 1'b1;
            case (func_r)
              sra_pkg::F_ADD: res_nxt = rdata_r + b_r;
              sra_pkg::F_SUB: res_nxt = rdata_r - b_r;
              sra_pkg::F_MUL: res_nxt = mul_ab;
              sra_pkg::F_DIV, sra_pkg::F_MOD: begin
                if (b_r == 32'd0) begin
                  wrote_nxt = 1'b0; dz_nxt = 1'b1;
                end else state_nxt = S_DIV;
              end
              sra_pkg::F_POW: begin
                if (b_r[31]) begin
                  if (rdata_r == 32'd1) res_nxt = 32'd1;
                  else if (rdata_r == 32'hFFFFFFFF) res_nxt = b_r[0] ? 32'hFFFFFFFF : 32'd1;
                  else res_nxt = 32'd0;
                end else state_nxt = S_POW;
              end
              sra_pkg::F_AND: res_nxt = rdata_r & b_r;
              sra_pkg::F_OR:  res_nxt = rdata_r | b_r;
              sra_pkg::F_XOR: res_nxt = rdata_r ^ b_r;
              sra_pkg::F_SHL: res_nxt = rdata_r << b_r[4:0];
              sra_pkg::F_SHR: res_nxt = 32'($signed(rdata_r) >>> b_r[4:0]);
              default: wrote_nxt = 1'b0;
            endcase
          end
          default: ;
        endcase
      end
      S_DIV: if (cnt_r == 6'd32) begin
        state_nxt = S_FIN;
        if (func_r == sra_pkg::F_DIV) res_nxt = qneg_r ? -q_r : q_r;
        else res_nxt = rneg_r ? -rem_r : rem_r;
      end
      S_POW: if (exp_r == 32'd0) begin
        state_nxt = S_FIN;
        res_nxt = acc_r;
      end
      S_FIN: if (out_tvalid && out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      line_r     <= 32'd0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_EXE && !cli_r) begin
        if (op_r == sra_pkg::OP_CMP && !cmp) line_r <= line_r + skip_r;
        if (op_r == sra_pkg::OP_JUMP)
          line_r <= (func_r == sra_pkg::J_REL) ? line_r + b_r : b_r - 32'd1;
      end
      // first FIN cycle writes back, then the beat is shown
      if (state_r == S_FIN && !out_tvalid) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    wrote_r <= wrote_nxt;
    dz_r    <= dz_nxt;
    if (state_r == S_IDLE && in_tvalid) begin
      op_r   <= in_tdata[2:0];
      tgt_r  <= sra_pkg::wrap_idx(32'($signed(in_tdata[18:3])));
      src_r  <= sra_pkg::wrap_idx(32'($signed(in_tdata[34:19])));
      func_r <= in_tdata[38:35];
      opnd_r <= in_tdata[70:39];
      oidx_r <= sra_pkg::wrap_idx(in_tdata[70:39]);
      oreg_r <= in_tdata[71];
      skip_r <= in_tdata[103:72];
      cli_r  <= in_tdata[104];
    end
    if (state_r == S_RDA) b_r <= oreg_r ? rdata_r : opnd_r;
    if (state_r == S_EXE) begin
      cnt_r  <= 6'd0;
      q_r    <= ua;
      rem_r  <= 32'd0;
      dvs_r  <= ub;
      qneg_r <= sa[31] ^ sb[31];
      rneg_r <= sa[31];
      acc_r  <= 32'd1;
      base_r <= rdata_r;
      exp_r  <= b_r;
    end
    if (state_r == S_DIV && cnt_r != 6'd32) begin
      cnt_r <= cnt_r + 6'd1;
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
    if (state_r == S_POW && exp_r != 32'd0) begin
      if (exp_r[0]) acc_r <= pow_m1;
      base_r <= pow_m2;
      exp_r  <= exp_r >> 1;
    end
  end
endmodule
`default_nettype wire
